// ----- rtl/rgvn_pkg.sv -----
// shared types and constants of the reciprocal grid vector and norm unit
package rgvn_pkg;

  localparam int IDX_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int COL_W     = 60;
  localparam int FOLD_W    = 12;
  localparam int VEC_W     = 32;
  localparam int SQ_W      = 64;
  localparam int CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COL_I  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_J  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_K  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] index_i;
    logic [IDX_W-1:0] index_j;
    logic [IDX_W-1:0] index_k;
  } in_req_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic [VEC_W-1:0]        vec_length;
  } out_rsp_t;

  typedef struct packed {
    logic [COL_W-1:0]  recip_col_i;
    logic [COL_W-1:0]  recip_col_j;
    logic [COL_W-1:0]  recip_col_k;
    logic [SIZE_W-1:0] grid_size_y;
    logic [SIZE_W-1:0] grid_size_z;
  } cfg_t;

  // one request on its way through the square root chain
  typedef struct packed {
    logic [SQ_W-1:0]         rem;
    logic [VEC_W-1:0]        root;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
  } sqrt_work_t;

endpackage

// ----- rtl/rgvn_if.sv -----
// request and result channel interfaces
interface rgvn_in_if;
  import rgvn_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rgvn_out_if;
  import rgvn_pkg::*;
  logic     valid;
  logic     ready;
  out_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/rgvn_vec_pipe.sv -----
// front pipeline: index folding, matrix product, saturation, sum of squares
module rgvn_vec_pipe #(
  parameter int GRID_MAX   = 1024,
  parameter int COEF_WIDTH = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rgvn_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rgvn_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rgvn_pkg::sqrt_work_t out_work_o
);
  import rgvn_pkg::*;

  localparam int NumStages = 5;
  localparam int ProdW     = COEF_WIDTH + FOLD_W;
  localparam int SumW      = (ProdW + 2 > VEC_W + 1) ? ProdW + 2 : VEC_W + 1;
  localparam logic [SIZE_W+1:0] GridCap = (SIZE_W + 2)'(GRID_MAX);

  function automatic logic signed [FOLD_W-1:0] fold(input logic [IDX_W-1:0]  idx,
                                                    input logic [SIZE_W-1:0] size);
    logic [SIZE_W+1:0] cap;
    logic [SIZE_W-1:0] sz;
    cap = (SIZE_W + 2)'(size);
    if (cap > GridCap) begin
      cap = GridCap;
    end
    sz = cap[SIZE_W-1:0];
    if (SIZE_W'(idx) > (sz >> 1)) begin
      return signed'(FOLD_W'(idx)) - signed'(FOLD_W'(sz));
    end
    return signed'(FOLD_W'(idx));
  endfunction

  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   adv;

  logic signed [FOLD_W-1:0] m_q [3];
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [VEC_W-1:0]  vec2_q [3];
  logic signed [VEC_W-1:0]  vec3_q [3];
  logic signed [VEC_W-1:0]  vec4_q [3];
  logic [SQ_W-1:0]          sq_q [3];
  logic [SQ_W-1:0]          sumsq_q;

  logic [2:0][63:0]                col_ext;
  logic signed [COEF_WIDTH-1:0]    coef [3][3];
  logic signed [ProdW-1:0]         prod_d [3][3];
  logic signed [VEC_W-1:0]         vec_d [3];
  logic [SQ_W-1:0]                 sq_d [3];
  logic signed [SumW-1:0]          sum_w [3];
  logic [VEC_W-1:0]                mag [3];

  // a stage loads when it is empty or its contents move on
  always_comb begin
    adv[NumStages] = out_ready_i;
    for (int s = NumStages - 1; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign in_ready_o = adv[0];

  always_comb begin
    col_ext[0] = 64'(cfg_i.recip_col_i);
    col_ext[1] = 64'(cfg_i.recip_col_j);
    col_ext[2] = 64'(cfg_i.recip_col_k);
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        coef[a][c]   = signed'(col_ext[a][c*COEF_WIDTH +: COEF_WIDTH]);
        // c is the component, a the index axis
        prod_d[c][a] = ProdW'(coef[a][c]) * ProdW'(m_q[a]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      sum_w[c] = SumW'(prod_q[c][0]) + SumW'(prod_q[c][1]) + SumW'(prod_q[c][2]);
      if (&sum_w[c][SumW-1:VEC_W-1] || ~|sum_w[c][SumW-1:VEC_W-1]) begin
        vec_d[c] = sum_w[c][VEC_W-1:0];
      end else if (sum_w[c][SumW-1]) begin
        vec_d[c] = {1'b1, {(VEC_W-1){1'b0}}};
      end else begin
        vec_d[c] = {1'b0, {(VEC_W-1){1'b1}}};
      end
      mag[c]  = vec2_q[c][VEC_W-1] ? (~vec2_q[c] + 1'b1) : vec2_q[c];
      sq_d[c] = SQ_W'(mag[c]) * SQ_W'(mag[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (adv[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      m_q[0] <= signed'(FOLD_W'(in_req_i.index_i));
      m_q[1] <= fold(in_req_i.index_j, cfg_i.grid_size_y);
      m_q[2] <= fold(in_req_i.index_k, cfg_i.grid_size_z);
    end
    if (adv[1]) begin
      prod_q <= prod_d;
    end
    if (adv[2]) begin
      vec2_q <= vec_d;
    end
    if (adv[3]) begin
      sq_q   <= sq_d;
      vec3_q <= vec2_q;
    end
    if (adv[4]) begin
      sumsq_q <= sq_q[0] + sq_q[1] + sq_q[2];
      vec4_q  <= vec3_q;
    end
  end

  assign out_valid_o      = valid_q[NumStages-1];
  assign out_work_o.rem   = sumsq_q;
  assign out_work_o.root  = '0;
  assign out_work_o.vec_x = vec4_q[0];
  assign out_work_o.vec_y = vec4_q[1];
  assign out_work_o.vec_z = vec4_q[2];

endmodule

// ----- rtl/rgvn_sqrt_cell.sv -----
// one cell of the square root chain: settles one root bit
module rgvn_sqrt_cell #(
  parameter int BIT_POS = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rgvn_pkg::sqrt_work_t in_work_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rgvn_pkg::sqrt_work_t out_work_o
);
  import rgvn_pkg::*;

  logic       valid_q;
  sqrt_work_t work_q;
  sqrt_work_t work_d;
  logic [SQ_W-1:0] trial;

  assign in_ready_o = !valid_q || out_ready_i;

  // remainder holds n - root^2; try setting this bit of the root
  always_comb begin
    work_d = in_work_i;
    trial  = (SQ_W'(in_work_i.root) << (BIT_POS + 1)) | (SQ_W'(1) << (2 * BIT_POS));
    if (in_work_i.rem >= trial) begin
      work_d.rem  = in_work_i.rem - trial;
      work_d.root = in_work_i.root | (VEC_W'(1) << BIT_POS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;

endmodule

// ----- rtl/reciprocal_grid_vector_and_norm_unit.sv -----
// pipeline: 5 front stages, then 32 root cells, from request to result
// throughput: one request per cycle while the result is not held up; each root cell settles one bit of the length
// every stage holds its own valid bit, so bubbles close up and a waiting result
// stalls only the stages behind it that are full
// reset: pipeline emptied, columns cleared to zero, both grid sizes set to one
module reciprocal_grid_vector_and_norm_unit #(
  parameter int GRID_MAX   = 1024,
  parameter int COEF_WIDTH = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rgvn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgvn_pkg::COL_W-1:0]     cfg_wdata_i,
  rgvn_in_if.sink                        in_i,
  rgvn_out_if.source                     out_o
);
  import rgvn_pkg::*;

  localparam int NumCells = VEC_W;

  cfg_t cfg_q;

  // configuration registers; the user must write them only while the unit is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip_col_i <= '0;
      cfg_q.recip_col_j <= '0;
      cfg_q.recip_col_k <= '0;
      cfg_q.grid_size_y <= SIZE_W'(1);
      cfg_q.grid_size_z <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COL_I:  cfg_q.recip_col_i <= cfg_wdata_i;
        CFG_COL_J:  cfg_q.recip_col_j <= cfg_wdata_i;
        CFG_COL_K:  cfg_q.recip_col_k <= cfg_wdata_i;
        CFG_SIZE_Y: cfg_q.grid_size_y <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SIZE_Z: cfg_q.grid_size_z <= cfg_wdata_i[SIZE_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // links of the chain: node 0 leaves the front pipeline, the last one is the result
  logic       node_valid [NumCells+1];
  logic       node_ready [NumCells+1];
  sqrt_work_t node_work  [NumCells+1];

  // folding, matrix product, saturation and squared length
  rgvn_vec_pipe #(
    .GRID_MAX   (GRID_MAX),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_vec_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_req_i    (in_i.payload),
    .out_valid_o (node_valid[0]),
    .out_ready_i (node_ready[0]),
    .out_work_o  (node_work[0])
  );

  // square root chain, most significant root bit first
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    rgvn_sqrt_cell #(
      .BIT_POS (NumCells - 1 - g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (node_valid[g]),
      .in_ready_o  (node_ready[g]),
      .in_work_i   (node_work[g]),
      .out_valid_o (node_valid[g+1]),
      .out_ready_i (node_ready[g+1]),
      .out_work_o  (node_work[g+1])
    );
  end

  // the last cell's register is the output register
  assign node_ready[NumCells]     = out_o.ready;
  assign out_o.valid              = node_valid[NumCells];
  assign out_o.payload.vec_x      = node_work[NumCells].vec_x;
  assign out_o.payload.vec_y      = node_work[NumCells].vec_y;
  assign out_o.payload.vec_z      = node_work[NumCells].vec_z;
  assign out_o.payload.vec_length = node_work[NumCells].root;

endmodule
